// File: design/torq_pkg.sv
`default_nettype none

package torq_pkg;

    localparam int TIME_W  = 15;
    localparam int ID_W    = 4;
    localparam int COUNT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] req_time;
        logic [ID_W-1:0]   req_id;
    } entry_t;

    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/torq_cell.sv
`default_nettype none

module torq_cell (
    input  wire logic                clk,
    input  wire torq_pkg::cell_ctl_t ctl,
    input  wire torq_pkg::entry_t    new_entry,
    input  wire logic                occupied,
    input  wire logic                prev_cmp,
    input  wire torq_pkg::entry_t    prev_entry,
    input  wire torq_pkg::entry_t    next_entry,
    output torq_pkg::entry_t         entry,
    output logic                     cmp
);

    torq_pkg::entry_t entry_reg;
    torq_pkg::entry_t entry_next;
    logic             sorts_before;

    always_comb
    begin
        sorts_before = (new_entry.req_time < entry_reg.req_time) ||
                       ((new_entry.req_time == entry_reg.req_time) &&
                        (new_entry.req_id < entry_reg.req_id));
        cmp = !occupied || sorts_before;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_in)
        begin
            if (prev_cmp)
            begin
                entry_next = prev_entry;
            end
            else if (cmp)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctl.shift_out)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: design/timestamp_ordered_request_queue_core.sv
// Channel   Ports                                              Handshake
// request   opcode, req_time, req_id                           start and not busy
// result    head_valid, head_time, head_id, entry_count,       done, one cycle
//           status
//
// Each request's result is shown on the cycle that follows it.
// The row of cells compares and shifts in parallel, so busy never rises.
// Reset empties the queue; the stored entries themselves are not cleared.
// The receiver cannot stall, so a result is present for one cycle only.

`default_nettype none

module timestamp_ordered_request_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           opcode,
    input  wire logic [torq_pkg::TIME_W-1:0]    req_time,
    input  wire logic [torq_pkg::ID_W-1:0]      req_id,
    output logic                                done,
    output logic                                head_valid,
    output logic [torq_pkg::TIME_W-1:0]         head_time,
    output logic [torq_pkg::ID_W-1:0]           head_id,
    output logic [torq_pkg::COUNT_W-1:0]        entry_count,
    output logic [1:0]                          status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                done_reg;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic                accept;
    logic                full;
    logic                empty;
    torq_pkg::cell_ctl_t ctl;
    torq_pkg::entry_t    new_entry;
    torq_pkg::entry_t    ent [QUEUE_DEPTH];
    logic                cmp [QUEUE_DEPTH];
    logic [CW+torq_pkg::COUNT_W-1:0] count_wide;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_entry = '{req_time: req_time, req_id: req_id};

    always_comb
    begin
        ctl.shift_in  = accept && (opcode == torq_pkg::OP_INSERT) && !full;
        ctl.shift_out = accept && (opcode == torq_pkg::OP_REMOVE) && !empty;
        count_next    = count_reg;
        status_next   = torq_pkg::ST_OK;
        if (ctl.shift_in)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.shift_out)
        begin
            count_next = count_reg - CW'(1);
        end
        if (opcode == torq_pkg::OP_INSERT)
        begin
            if (full)
            begin
                status_next = torq_pkg::ST_FULL;
            end
        end
        else if (empty)
        begin
            status_next = torq_pkg::ST_EMPTY;
        end
    end

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            logic             prev_cmp;
            torq_pkg::entry_t prev_entry;
            torq_pkg::entry_t next_entry;

            if (k == 0)
            begin : g_first
                assign prev_cmp   = 1'b0;
                assign prev_entry = ent[0];
            end
            else
            begin : g_mid
                assign prev_cmp   = cmp[k-1];
                assign prev_entry = ent[k-1];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_entry = ent[k];
            end
            else
            begin : g_inner
                assign next_entry = ent[k+1];
            end

            torq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .occupied   (CW'(k) < count_reg),
                .prev_cmp   (prev_cmp),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .entry      (ent[k]),
                .cmp        (cmp[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    assign count_wide  = {{torq_pkg::COUNT_W{1'b0}}, count_reg};
    assign done        = done_reg;
    assign head_valid  = !empty;
    assign head_time   = empty ? '0 : ent[0].req_time;
    assign head_id     = empty ? '0 : ent[0].req_id;
    assign entry_count = count_wide[torq_pkg::COUNT_W-1:0];
    assign status      = status_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("A request did not produce a result on the next cycle.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("The entry count exceeds the queue depth.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == torq_pkg::ST_FULL) |-> full)
        else $error("A dropped insert was flagged while the queue had room.");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == torq_pkg::OP_REMOVE) && !empty
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("A remove did not lower the entry count by one.");

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_COUNT = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int TIME_W       = torq_pkg::TIME_W;
    localparam int ID_W         = torq_pkg::ID_W;
    localparam int COUNT_W      = torq_pkg::COUNT_W;

    typedef struct packed {
        logic               head_valid;
        logic [TIME_W-1:0]  head_time;
        logic [ID_W-1:0]    head_id;
        logic [COUNT_W-1:0] entry_count;
        logic [1:0]         status;
    } head_result_t;

    class request_scoreboard;
        torq_pkg::entry_t entries[QUEUE_DEPTH];
        int               stored;
        head_result_t     expected_q[$];
        int               mismatches;
        int               checked;
        int               inserts;
        int               removes;
        int               full_drops;
        int               empty_removes;
        int               peak_count;

        function void note_request(logic op, logic [TIME_W-1:0] t,
                                   logic [ID_W-1:0] id);
            head_result_t r;
            int           pos;
            r = '0;
            r.status = torq_pkg::ST_OK;
            if (op == torq_pkg::OP_INSERT)
            begin
                inserts++;
                if (stored >= QUEUE_DEPTH)
                begin
                    r.status = torq_pkg::ST_FULL;
                    full_drops++;
                end
                else
                begin
                    pos = stored;
                    for (int k = stored - 1; k >= 0; k--)
                    begin
                        if (t < entries[k].req_time ||
                            (t == entries[k].req_time && id < entries[k].req_id))
                            pos = k;
                    end
                    for (int k = stored; k > pos; k--)
                        entries[k] = entries[k-1];
                    entries[pos].req_time = t;
                    entries[pos].req_id   = id;
                    stored++;
                end
            end
            else
            begin
                removes++;
                if (stored == 0)
                begin
                    r.status = torq_pkg::ST_EMPTY;
                    empty_removes++;
                end
                else
                begin
                    for (int k = 0; k + 1 < stored; k++)
                        entries[k] = entries[k+1];
                    stored--;
                end
            end
            if (stored > peak_count)
                peak_count = stored;
            if (stored > 0)
            begin
                r.head_valid = 1'b1;
                r.head_time  = entries[0].req_time;
                r.head_id    = entries[0].req_id;
            end
            r.entry_count = stored[COUNT_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(head_result_t act);
            head_result_t exp_r;
            logic         bad;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result with no request outstanding: ",
                              "valid=%0d time=%0d id=%0d count=%0d status=%0d"},
                             act.head_valid, act.head_time, act.head_id,
                             act.entry_count, act.status);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            bad = (act.head_valid !== exp_r.head_valid) ||
                  (act.head_time !== exp_r.head_time) ||
                  (act.head_id !== exp_r.head_id) ||
                  (act.entry_count !== exp_r.entry_count) ||
                  (act.status !== exp_r.status);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result %0d expected valid=%0d time=%0d id=%0d ",
                              "count=%0d status=%0d, got valid=%0d time=%0d id=%0d ",
                              "count=%0d status=%0d"},
                             checked, exp_r.head_valid, exp_r.head_time, exp_r.head_id,
                             exp_r.entry_count, exp_r.status, act.head_valid,
                             act.head_time, act.head_id, act.entry_count, act.status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               opcode = torq_pkg::OP_INSERT;
    logic [TIME_W-1:0]  req_time = '0;
    logic [ID_W-1:0]    req_id = '0;
    logic               busy;
    logic               done;
    logic               head_valid;
    logic [TIME_W-1:0]  head_time;
    logic [ID_W-1:0]    head_id;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;

    request_scoreboard sb = new();
    int                cycle_count = 0;

    timestamp_ordered_request_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .req_time   (req_time),
        .req_id     (req_id),
        .done       (done),
        .head_valid (head_valid),
        .head_time  (head_time),
        .head_id    (head_id),
        .entry_count(entry_count),
        .status     (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result({head_valid, head_time, head_id, entry_count, status});
            if (start && !busy)
                sb.note_request(opcode, req_time, req_id);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timestamp_ordered_request_queue_core test failed");
        $finish;
    end

    task automatic send_request(logic op, logic [TIME_W-1:0] t, logic [ID_W-1:0] id);
        @(negedge clk);
        start    <= 1'b1;
        opcode   <= op;
        req_time <= t;
        req_id   <= id;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_time(int mode, logic [TIME_W-1:0] tie_base);
        case (mode)
            0: return TIME_W'($urandom_range(0, 32767));
            1: return tie_base + TIME_W'($urandom_range(0, 3));
            default: return ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
    endfunction

    initial
    begin
        int                sent;
        int                phase_kind;
        int                phase_left;
        int                burst_left;
        int                insert_pct;
        int                time_mode;
        logic [TIME_W-1:0] tie_base;
        logic              op;
        logic              paused;

        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        idle_cycles(2);

        // Directed: remove on empty, fill with extremes and ties, overflow, then remove.
        send_request(torq_pkg::OP_REMOVE, '1, '1);
        send_request(torq_pkg::OP_INSERT, 15'd32767, 4'd15);
        send_request(torq_pkg::OP_INSERT, 15'd0, 4'd0);
        send_request(torq_pkg::OP_INSERT, 15'd100, 4'd7);
        send_request(torq_pkg::OP_INSERT, 15'd100, 4'd3);
        send_request(torq_pkg::OP_INSERT, 15'd100, 4'd7);
        send_request(torq_pkg::OP_INSERT, 15'd100, 4'd15);
        send_request(torq_pkg::OP_INSERT, 15'd0, 4'd15);
        send_request(torq_pkg::OP_INSERT, 15'd32767, 4'd0);
        send_request(torq_pkg::OP_INSERT, 15'd5000, 4'd8);
        send_request(torq_pkg::OP_INSERT, 15'd100, 4'd0);
        send_request(torq_pkg::OP_INSERT, 15'd16384, 4'd4);
        send_request(torq_pkg::OP_INSERT, 15'd1, 4'd1);
        send_request(torq_pkg::OP_INSERT, 15'd32766, 4'd14);
        send_request(torq_pkg::OP_INSERT, 15'd100, 4'd3);
        send_request(torq_pkg::OP_INSERT, 15'd2, 4'd9);
        send_request(torq_pkg::OP_INSERT, 15'd200, 4'd6);
        send_request(torq_pkg::OP_INSERT, 15'd0, 4'd0);
        send_request(torq_pkg::OP_REMOVE, '0, '0);
        send_request(torq_pkg::OP_REMOVE, '1, '0);
        wait_drained();

        sent       = 0;
        phase_left = 0;
        burst_left = 0;
        paused     = 1'b0;
        phase_kind = 0;
        insert_pct = 50;
        time_mode  = 0;
        tie_base   = '0;
        while (sent < RANDOM_COUNT)
        begin
            if (phase_left == 0)
            begin
                phase_kind = $urandom_range(0, 3);
                phase_left = $urandom_range(10, 60);
                tie_base   = TIME_W'($urandom_range(0, 32767));
                case (phase_kind)
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 6));
            end
            if (!paused && sent == RANDOM_COUNT / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if (phase_kind == 3)
                time_mode = ($urandom_range(0, 3) == 0) ? 2 : 1;
            else
                time_mode = ($urandom_range(0, 9) == 0) ? 2 : 0;
            op = ($urandom_range(1, 100) <= insert_pct) ?
                 torq_pkg::OP_INSERT : torq_pkg::OP_REMOVE;
            send_request(op, pick_time(time_mode, tie_base), ID_W'($urandom_range(0, 15)));
            sent++;
            phase_left--;
            burst_left--;
        end

        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);

        if (sb.pending() != 0)
            $display("ERROR: %0d expected results never arrived", sb.pending());
        $display({"Ran %0d inserts (%0d dropped on a full queue) and %0d removes ",
                  "(%0d on an empty queue)."},
                 sb.inserts, sb.full_drops, sb.removes, sb.empty_removes);
        $display("Peak occupancy %0d of %0d; %0d results checked, %0d mismatches.",
                 sb.peak_count, QUEUE_DEPTH, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("timestamp_ordered_request_queue_core test passed");
        else
            $display("timestamp_ordered_request_queue_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
design/torq_pkg.sv
design/torq_cell.sv
design/timestamp_ordered_request_queue_core.sv
tb/sv/tb.sv
